>>> rtl/hhnc_pkg.sv
// Shared types, constants and name tables for the HTTP header name classifier.
`default_nettype none
package hhnc_pkg;

  localparam int unsigned NameCount = 26;
  localparam int unsigned TextBits  = 160;

  typedef logic [4:0]           code_t;
  typedef logic [4:0]           pos_t;
  typedef logic [NameCount-1:0] mask_t;
  typedef logic [TextBits-1:0]  text_t;

  localparam code_t CodeUnknown = 5'd26;
  localparam pos_t  MaxNameLen  = 5'd19;
  localparam pos_t  PosLimit    = 5'd31;
  localparam logic [7:0] CaseBit = 8'h20;

  // Name length in bytes, by code
  function automatic pos_t name_len(input code_t idx);
    pos_t len;
    case (idx)
      5'd0:    len = 5'd6;
      5'd1:    len = 5'd14;
      5'd2:    len = 5'd15;
      5'd3:    len = 5'd15;
      5'd4:    len = 5'd13;
      5'd5:    len = 5'd10;
      5'd6:    len = 5'd12;
      5'd7:    len = 5'd14;
      5'd8:    len = 5'd6;
      5'd9:    len = 5'd7;
      5'd10:   len = 5'd13;
      5'd11:   len = 5'd4;
      5'd12:   len = 5'd8;
      5'd13:   len = 5'd17;
      5'd14:   len = 5'd13;
      5'd15:   len = 5'd8;
      5'd16:   len = 5'd19;
      5'd17:   len = 5'd10;
      5'd18:   len = 5'd6;
      5'd19:   len = 5'd7;
      5'd20:   len = 5'd5;
      5'd21:   len = 5'd17;
      5'd22:   len = 5'd10;
      5'd23:   len = 5'd3;
      5'd24:   len = 5'd15;
      5'd25:   len = 5'd17;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Name text, right-justified: the first byte sits highest
  function automatic text_t name_text(input code_t idx);
    text_t t;
    case (idx)
      5'd0:    t = TextBits'("accept");
      5'd1:    t = TextBits'("accept-charset");
      5'd2:    t = TextBits'("accept-encoding");
      5'd3:    t = TextBits'("accept-language");
      5'd4:    t = TextBits'("authorization");
      5'd5:    t = TextBits'("connection");
      5'd6:    t = TextBits'("content-type");
      5'd7:    t = TextBits'("content-length");
      5'd8:    t = TextBits'("cookie");
      5'd9:    t = TextBits'("cookie2");
      5'd10:   t = TextBits'("cache-control");
      5'd11:   t = TextBits'("host");
      5'd12:   t = TextBits'("if-match");
      5'd13:   t = TextBits'("if-modified-since");
      5'd14:   t = TextBits'("if-none-match");
      5'd15:   t = TextBits'("if-range");
      5'd16:   t = TextBits'("if-unmodified-since");
      5'd17:   t = TextBits'("keep-alive");
      5'd18:   t = TextBits'("pragma");
      5'd19:   t = TextBits'("referer");
      5'd20:   t = TextBits'("range");
      5'd21:   t = TextBits'("transfer-encoding");
      5'd22:   t = TextBits'("user-agent");
      5'd23:   t = TextBits'("via");
      5'd24:   t = TextBits'("x-forwarded-for");
      // x- cache purge header
      5'd25:   t = TextBits'(136'h782d_6c69_7465_7370_6565_642d_7075_7267_65);
      default: t = '0;
    endcase
    return t;
  endfunction

  // Only A-Z fold to lower case
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) ? (c | CaseBit) : c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/hhnc_if.sv
// Valid/ready channel interfaces for name bytes in and classification results out.
`default_nettype none
interface hhnc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       last_byte;

  modport source (output valid, output name_byte, output last_byte, input ready);
  modport sink   (input valid, input name_byte, input last_byte, output ready);
endinterface

interface hhnc_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] header_code;
  logic       known;

  modport source (output valid, output header_code, output known, input ready);
  modport sink   (input valid, input header_code, input known, output ready);
endinterface
`default_nettype wire

>>> rtl/hhnc_match.sv
// Candidate mask and byte position state, per-byte mask update and final code pick.
`default_nettype none
module hhnc_match (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [7:0]         name_byte_i,
  input  wire logic               last_byte_i,
  output hhnc_pkg::code_t         code_o
);

  hhnc_pkg::mask_t mask_q, mask_d, mask_upd;
  hhnc_pkg::pos_t  pos_q, pos_d, pos_next;
  logic [7:0]      c;

  always_comb begin
    hhnc_pkg::pos_t  len;
    hhnc_pkg::pos_t  byte_ofs;
    hhnc_pkg::text_t txt;
    logic [7:0]      ch;
    c = hhnc_pkg::fold_case(name_byte_i);
    mask_upd = mask_q;
    for (int i = 0; i < hhnc_pkg::NameCount; i++) begin
      len      = hhnc_pkg::name_len(5'(i));
      txt      = hhnc_pkg::name_text(5'(i));
      byte_ofs = 5'(len - pos_q - 5'd1);
      ch       = txt[{byte_ofs, 3'b000} +: 8];
      if (pos_q >= hhnc_pkg::MaxNameLen || pos_q >= len || ch != c) begin
        mask_upd[i] = 1'b0;
      end
    end
    pos_next = (pos_q < hhnc_pkg::PosLimit) ? 5'(pos_q + 5'd1) : hhnc_pkg::PosLimit;
  end

  // First surviving name whose length equals the received length
  always_comb begin
    code_o = hhnc_pkg::CodeUnknown;
    if (pos_next <= hhnc_pkg::MaxNameLen) begin
      for (int i = hhnc_pkg::NameCount - 1; i >= 0; i--) begin
        if (mask_upd[i] && hhnc_pkg::name_len(5'(i)) == pos_next) begin
          code_o = 5'(i);
        end
      end
    end
  end

  always_comb begin
    mask_d = mask_q;
    pos_d  = pos_q;
    if (step_i) begin
      if (last_byte_i) begin
        mask_d = '1;
        pos_d  = '0;
      end else begin
        mask_d = mask_upd;
        pos_d  = pos_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '1;
      pos_q  <= '0;
    end else begin
      mask_q <= mask_d;
      pos_q  <= pos_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/http_header_name_classifier_unit.sv
// Top level of the HTTP header name classifier: input register, matcher and result register.
`default_nettype none
// Takes a header name one byte per request (last_byte marks the final byte) and, on
// the final byte, returns one result: header_code 0-25 for an exact ASCII
// case-insensitive match against the fixed name list, or 26 with known low for an
// unknown name or one longer than 19 bytes. Non-final bytes give no result. One byte
// is accepted every cycle while no final byte is held back; a byte passes from the input
// register through the candidate-mask compare, and the result of its final byte is
// registered in the result register. Input and output stall independently: a waiting
// result only holds back a final byte behind it.
module http_header_name_classifier_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hhnc_in_if.sink    in_i,
  hhnc_out_if.source out_o
);

  logic            s1_valid_q, s1_valid_d;
  logic [7:0]      s1_byte_q;
  logic            s1_last_q;
  logic            advance;
  logic            in_take;
  logic            out_valid_q, out_valid_d;
  hhnc_pkg::code_t code_q, code;

  assign advance  = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_take  = in_i.valid && in_i.ready;

  hhnc_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .name_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .code_o      (code)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_i.name_byte;
      s1_last_q <= in_i.last_byte;
    end
    if (advance && s1_last_q) begin
      code_q <= code;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.header_code = code_q;
  assign out_o.known       = (code_q != hhnc_pkg::CodeUnknown);

endmodule
`default_nettype wire
